FILE: hdl/rational_arith_reduce_macros.svh
// assertion macros for the rational arithmetic block
// included by the top level; no other dependencies
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RAR_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define RAR_ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) else $error(msg);

`else

`define RAR_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)

`define RAR_ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg)

`endif

`endif

FILE: hdl/rar_pkg.sv
// shared types, widths and codes for the rational arithmetic block
// no dependencies; used by rar_ctrl, rar_dp and rational_arith_reduce
`default_nettype none

package rar_pkg;

    // operand and derived widths
    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    localparam int OUT_W         = 33;
    localparam int K_W           = $clog2(MAG_W);
    localparam int CNT_W         = $clog2(MAG_W);

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic sign;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic zero_part;
        logic gcd_equal;
    } sts_t;

endpackage

`default_nettype wire

FILE: hdl/rar_dp.sv
// datapath: operand capture, cross products, sign/magnitude split,
// binary gcd, shared-divisor restoring division and output register; uses rar_pkg
`default_nettype none

module rar_dp
(
    input  wire logic                                    clk,
    input  wire rar_pkg::cmd_t                           cmd_in,
    output rar_pkg::sts_t                                sts,
    input  wire logic [1:0]                              cmd,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] num_a,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] den_a,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] num_b,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] den_b,
    output logic signed [rar_pkg::OUT_W-1:0]             num_out,
    output logic signed [rar_pkg::OUT_W-1:0]             den_out
);

    // captured operands
    logic [1:0]                               op_reg;
    logic signed [rar_pkg::OPERAND_WIDTH-1:0] a_reg;
    logic signed [rar_pkg::OPERAND_WIDTH-1:0] b_reg;
    logic signed [rar_pkg::OPERAND_WIDTH-1:0] c_reg;
    logic signed [rar_pkg::OPERAND_WIDTH-1:0] d_reg;

    // products
    logic signed [rar_pkg::PROD_W-1:0] m0_reg, m0_next;
    logic signed [rar_pkg::PROD_W-1:0] m1_reg, m1_next;
    logic signed [rar_pkg::PROD_W-1:0] m2_reg, m2_next;

    // sign and magnitude of the raw parts
    logic                      nneg_reg, nneg_next;
    logic                      dneg_reg, dneg_next;
    logic [rar_pkg::MAG_W-1:0] nmag_reg, nmag_next;
    logic [rar_pkg::MAG_W-1:0] dmag_reg, dmag_next;

    // gcd working values
    logic [rar_pkg::MAG_W-1:0] u_reg, u_next;
    logic [rar_pkg::MAG_W-1:0] v_reg, v_next;
    logic [rar_pkg::K_W-1:0]   k_reg, k_next;
    logic [rar_pkg::MAG_W-1:0] g_reg, g_next;

    // division: quotient shifts in while the dividend shifts out
    logic [rar_pkg::MAG_W-1:0] qn_reg, qn_next;
    logic [rar_pkg::MAG_W-1:0] qd_reg, qd_next;
    logic [rar_pkg::MAG_W-1:0] rn_reg, rn_next;
    logic [rar_pkg::MAG_W-1:0] rd_reg, rd_next;

    // result register
    logic signed [rar_pkg::OUT_W-1:0] num_out_reg, num_out_next;
    logic signed [rar_pkg::OUT_W-1:0] den_out_reg, den_out_next;

    // combinational helpers
    logic signed [rar_pkg::OPERAND_WIDTH-1:0] sel0, sel2;
    logic signed [rar_pkg::SUM_W-1:0]         sum_w, den_w;
    logic [rar_pkg::MAG_W:0]                  diff_uv, diff_vu;
    logic [rar_pkg::MAG_W:0]                  trial_n, trial_d;
    logic [rar_pkg::MAG_W-1:0]                res_n, res_d;

    // operand selection for the three multipliers
    assign sel0 = (op_reg == rar_pkg::OP_MUL) ? c_reg : d_reg;
    assign sel2 = (op_reg == rar_pkg::OP_DIV) ? c_reg : d_reg;

    // numerator sum and sign-extended denominator product
    always_comb
    begin
        case (op_reg)
            rar_pkg::OP_ADD: sum_w = rar_pkg::SUM_W'(m0_reg) + rar_pkg::SUM_W'(m1_reg);
            rar_pkg::OP_SUB: sum_w = rar_pkg::SUM_W'(m0_reg) - rar_pkg::SUM_W'(m1_reg);
            default:         sum_w = rar_pkg::SUM_W'(m0_reg);
        endcase
        den_w = rar_pkg::SUM_W'(m2_reg);
    end

    // gcd subtractors, borrow bit tells which is larger
    assign diff_uv = {1'b0, u_reg} - {1'b0, v_reg};
    assign diff_vu = {1'b0, v_reg} - {1'b0, u_reg};

    // restoring division trial subtractions
    assign trial_n = {rn_reg, qn_reg[rar_pkg::MAG_W-1]} - {1'b0, g_reg};
    assign trial_d = {rd_reg, qd_reg[rar_pkg::MAG_W-1]} - {1'b0, g_reg};

    // unreduced parts when either is zero
    assign res_n = sts.zero_part ? nmag_reg : qn_reg;
    assign res_d = sts.zero_part ? dmag_reg : qd_reg;

    // status
    assign sts.zero_part = (nmag_reg == '0) || (dmag_reg == '0);
    assign sts.gcd_equal = (u_reg == v_reg);

    // next-value logic
    always_comb
    begin
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        m2_next      = m2_reg;
        nneg_next    = nneg_reg;
        dneg_next    = dneg_reg;
        nmag_next    = nmag_reg;
        dmag_next    = dmag_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        num_out_next = num_out_reg;
        den_out_next = den_out_reg;

        // cross products
        if (cmd_in.mul)
        begin
            m0_next = a_reg * sel0;
            m1_next = c_reg * b_reg;
            m2_next = b_reg * sel2;
        end

        // split into sign and magnitude, seed the gcd
        if (cmd_in.sign)
        begin
            nneg_next = sum_w[rar_pkg::SUM_W-1];
            dneg_next = den_w[rar_pkg::SUM_W-1];
            nmag_next = rar_pkg::MAG_W'(nneg_next ? -sum_w : sum_w);
            dmag_next = rar_pkg::MAG_W'(dneg_next ? -den_w : den_w);
            u_next    = nmag_next;
            v_next    = dmag_next;
            k_next    = '0;
        end

        // one binary gcd step
        if (cmd_in.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + rar_pkg::K_W'(1);
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (!diff_uv[rar_pkg::MAG_W])
            begin
                u_next = diff_uv[rar_pkg::MAG_W:1];
            end
            else
            begin
                v_next = diff_vu[rar_pkg::MAG_W:1];
            end
        end

        // restore common factors of two, prime the dividers
        if (cmd_in.div_init)
        begin
            g_next  = u_reg << k_reg;
            qn_next = nmag_reg;
            qd_next = dmag_reg;
            rn_next = '0;
            rd_next = '0;
        end

        // one quotient bit for each part
        if (cmd_in.div_step)
        begin
            if (!trial_n[rar_pkg::MAG_W])
            begin
                rn_next = trial_n[rar_pkg::MAG_W-1:0];
                qn_next = {qn_reg[rar_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rn_next = {rn_reg[rar_pkg::MAG_W-2:0], qn_reg[rar_pkg::MAG_W-1]};
                qn_next = {qn_reg[rar_pkg::MAG_W-2:0], 1'b0};
            end
            if (!trial_d[rar_pkg::MAG_W])
            begin
                rd_next = trial_d[rar_pkg::MAG_W-1:0];
                qd_next = {qd_reg[rar_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rd_next = {rd_reg[rar_pkg::MAG_W-2:0], qd_reg[rar_pkg::MAG_W-1]};
                qd_next = {qd_reg[rar_pkg::MAG_W-2:0], 1'b0};
            end
        end

        // put signs back and load the result
        if (cmd_in.load_out)
        begin
            num_out_next = nneg_reg ? -rar_pkg::OUT_W'(res_n) : rar_pkg::OUT_W'(res_n);
            den_out_next = dneg_reg ? -rar_pkg::OUT_W'(res_d) : rar_pkg::OUT_W'(res_d);
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd_in.load_in)
        begin
            op_reg <= cmd;
            a_reg  <= num_a;
            b_reg  <= den_a;
            c_reg  <= num_b;
            d_reg  <= den_b;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        m2_reg      <= m2_next;
        nneg_reg    <= nneg_next;
        dneg_reg    <= dneg_next;
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        num_out_reg <= num_out_next;
        den_out_reg <= den_out_next;
    end

    assign num_out = num_out_reg;
    assign den_out = den_out_reg;

endmodule

`default_nettype wire

FILE: hdl/rar_ctrl.sv
// controller state machine: sequences multiply, gcd, divide and output
// drives datapath commands and both handshakes; uses rar_pkg
`default_nettype none

module rar_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire rar_pkg::sts_t sts,
    output rar_pkg::cmd_t      cmd_out
);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_GCD   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [rar_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;

    // output register can take a new item
    assign out_free = !out_valid_reg || !out_stall;

    // state transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_out    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_out.load_in = 1'b1;
                    state_next      = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd_out.mul = 1'b1;
                state_next  = S_SIGN;
            end
            S_SIGN:
            begin
                cmd_out.sign = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (sts.zero_part)
                begin
                    state_next = S_OUT;
                end
                else if (sts.gcd_equal)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd_out.gcd_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd_out.div_init = 1'b1;
                cnt_next         = '0;
                state_next       = S_DIV;
            end
            S_DIV:
            begin
                cmd_out.div_step = 1'b1;
                cnt_next         = cnt_reg + rar_pkg::CNT_W'(1);
                if (cnt_reg == rar_pkg::CNT_W'(rar_pkg::MAG_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd_out.load_out = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_out.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/rational_arith_reduce.sv
// Rational arithmetic with reduction.
// Input channel (in_valid / in_stall) carries cmd (0 add, 1 subtract,
// 2 multiply, 3 divide) and two 16-bit signed fractions num_a/den_a and
// num_b/den_b. Output channel (out_valid / out_stall) carries the 33-bit
// signed reduced numerator and denominator, one result item per input item.
// An item moves when valid is high and stall is low at a rising edge.
// One item is processed at a time: in_stall stays high from acceptance until
// the result has been loaded into the output register. After acceptance the
// controller runs the cross products, the sign split, the binary gcd steps
// (one shift or subtract-and-shift per cycle), the restore of common factors
// of two, the restoring division (one quotient bit per cycle for both parts
// in parallel) and the output load, which waits while the output register
// holds an untaken result. If either raw part is zero the gcd and division
// are skipped and the parts are loaded unreduced.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver only holds the block once the next result is ready.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// out_valid; the datapath registers are not reset.
// deps: rar_pkg, rar_ctrl, rar_dp, rational_arith_reduce_macros.svh
`default_nettype none

`include "rational_arith_reduce_macros.svh"

module rational_arith_reduce
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic [1:0]                               cmd,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] num_a,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] den_a,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] num_b,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] den_b,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic signed [rar_pkg::OUT_W-1:0]              num_out,
    output logic signed [rar_pkg::OUT_W-1:0]              den_out
);

    rar_pkg::cmd_t ctl_cmd;
    rar_pkg::sts_t dp_sts;

    // sequencer
    rar_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (dp_sts),
        .cmd_out   (ctl_cmd)
    );

    // arithmetic
    rar_dp u_dp
    (
        .clk     (clk),
        .cmd_in  (ctl_cmd),
        .sts     (dp_sts),
        .cmd     (cmd),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b),
        .num_out (num_out),
        .den_out (den_out)
    );

    // no second item taken while one is in flight
    `RAR_ASSERT(a_single_item, clk, rst_n, in_valid && !in_stall |=> in_stall, "item accepted while busy")

    // a new result only appears after an item was being worked on
    `RAR_ASSERT(a_result_from_item, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without item")

    // never overwrite a result the receiver has not taken
    `RAR_ASSERT_NEVER(a_no_overwrite, clk, rst_n, ctl_cmd.load_out && out_valid && out_stall, "result overwritten")

endmodule

`default_nettype wire
